@@ design/ylga_pkg.sv @@
`default_nettype none

package ylga_pkg;

  // Defaults for the top-level parameters.
  localparam int GAMMA_LUT_INDEX_BITS_DEF = 10;
  localparam int FRACTION_BITS_DEF        = 16;

  // Pixel channel width and the width of the integer luma sum.
  localparam int CH_W  = 8;
  localparam int SUM_W = 18;

  // Luma weights in thousandths and the common scale of thousandths.
  localparam int LUMA_R = 299;
  localparam int LUMA_G = 587;
  localparam int LUMA_B = 114;
  localparam int MILLI  = 1000;

  // Divisors that bring the integer sums to fractions of one.
  localparam int Y_DIV      = 255000;
  localparam int CHROMA_DIV = 255000000;

  // Chroma difference scales in thousandths.
  localparam int CB_COEF = 568;
  localparam int CR_COEF = 713;

  // Reconstruction coefficients in thousandths.
  localparam int R_CR = 1371;
  localparam int G_CR = 698;
  localparam int G_CB = 336;
  localparam int B_CB = 1732;

  // Full-scale channel code.
  localparam int CH_MAX = 255;

  // Output scaling: the rounded value over 1000 is at most 255500, and
  // dividing it by 1000 goes through a reciprocal that is exact there.
  localparam int ACC_W           = 18;
  localparam int OUT_RECIP_SHIFT = 28;
  localparam int OUT_RECIP       = ((1 << OUT_RECIP_SHIFT) + MILLI - 1) / MILLI;
  localparam int OUT_RECIP_W     = 19;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Integer square root by the digit-pair method.
  function automatic logic [63:0] isqrt64(input logic [63:0] value);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = value;
    r  = 64'd0;
    bt = 64'd1 << 62;
    while (bt > v) begin
      bt = bt >> 2;
    end
    while (bt != 64'd0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Gamma ROM entry for index idx out of 2^ib steps, fb fraction bits.
  // A Q30 log2 by repeated squaring is scaled by 17/20 or 3/2, then taken
  // back through a Q30 exp2 built from square roots of two.
  function automatic logic [63:0] gamma_entry(input int unsigned idx,
                                              input int unsigned mode,
                                              input int unsigned ib,
                                              input int unsigned fb);
    int unsigned m;
    int unsigned b;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] d;
    logic [63:0] s;
    if (idx == 0) begin
      return 64'd0;
    end
    m = 0;
    while (m < 31 && (idx >> (m + 1)) != 0) begin
      m = m + 1;
    end
    frac = 64'd0;
    mant = 64'(idx) << (30 - m);
    for (b = 1; b <= 30; b++) begin
      mant = (mant * mant) >> 30;
      if (mant >= 2 * Q30_ONE) begin
        mant = mant >> 1;
        frac = frac | (64'd1 << (30 - b));
      end
    end
    mag = (64'(ib - m) << 30) - frac;
    if (mode != 0) begin
      scaled = mag * 64'd3 / 64'd2;
    end else begin
      scaled = mag * 64'd17 / 64'd20;
    end
    n = scaled >> 30;
    f = scaled & (Q30_ONE - 64'd1);
    r = Q30_ONE;
    d = isqrt64(64'd1 << 59);
    for (b = 1; b <= 30; b++) begin
      if (((f >> (30 - b)) & 64'd1) != 64'd0) begin
        r = (r * d) >> 30;
      end
      d = isqrt64(d << 30);
    end
    s = 64'(30 - fb) + n;
    if (s >= 64'd40) begin
      return 64'd0;
    end
    return (r + (64'd1 << (s - 64'd1))) >> s;
  endfunction

endpackage

`default_nettype wire

@@ design/ylga_cdiv.sv @@
`default_nettype none

// Rounded division of COEF * z * 2^F by the constant D, in three stages:
// partial products with a scaled reciprocal, their sum, then the offset
// add and the final shift.
module ylga_cdiv #(
  parameter int ZW   = ylga_pkg::SUM_W,
  parameter int COEF = 1,
  parameter int D    = ylga_pkg::Y_DIV,
  parameter int F    = ylga_pkg::FRACTION_BITS_DEF,
  parameter int QW   = ylga_pkg::FRACTION_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [ZW-1:0] z,
  output logic [QW-1:0] q
);

  import ylga_pkg::*;

  // The reciprocal M = ceil(2^K / D) makes the truncated product exact for
  // every numerator below 2^(XW + F + 1).
  localparam int CBW = $clog2(COEF + 1);
  localparam int XW  = ZW + CBW;
  localparam int DW  = $clog2(D + 1);
  localparam int K   = XW + F + 1 + DW;
  localparam int KW  = K + 1;
  localparam int MW  = K - DW + 2;
  localparam logic [KW-1:0] TWO_K = {1'b1, {K{1'b0}}};
  localparam logic [KW-1:0] M_FULL = (TWO_K + KW'(D) - KW'(1)) / KW'(D);
  localparam logic [MW-1:0] M = M_FULL[MW-1:0];

  // The coefficient folds into the reciprocal, the rounding half into HM.
  localparam int MCW = MW + CBW;
  localparam logic [MCW-1:0] MC = MCW'(M) * MCW'(COEF);
  localparam int CW  = (MCW + 2) / 3;
  localparam logic [3*CW-1:0] MCP = (3*CW)'(MC);
  localparam int HW  = DW + MW;
  localparam logic [HW-1:0] HM = HW'(M) * HW'(D / 2);
  localparam int PW  = ZW + 3 * CW;
  localparam int TW  = ((PW + F) > HW ? (PW + F) : HW) + 1;
  localparam int PPW = ZW + CW;

  logic [PPW-1:0] pp [3];
  logic [PW-1:0]  psum;
  logic [TW-1:0]  total;
  logic [TW-1:0]  total_shift;

  // Partial products of z with three slices of the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pp[j] <= PPW'(z) * PPW'(MCP[j*CW +: CW]);
      end
    end
  end

  // Sum of the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      psum <= (PW'(pp[2]) << (2 * CW)) + (PW'(pp[1]) << CW) + PW'(pp[0]);
    end
  end

  // Offset add and shift down to the quotient.
  always_comb begin
    total       = (TW'(psum) << F) + TW'(HM);
    total_shift = total >> K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= total_shift[QW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/ycbcr_luma_gamma_adjust.sv @@
`default_nettype none

// Channel  Signals                                      Beat
// in       in_valid, in_ready, red_in/green_in/blue_in  one RGB pixel
// out      out_valid, out_ready, red_out/.../blue_out   one adjusted RGB pixel
// cfg      cfg_we, cfg_wdata                            gamma_mode, taken at once
//
// One pixel enters per cycle while no output beat waits; the pipeline stages
// are luma sum, chroma differences, three divider stages, ROM index, ROM
// read, products, sums with clamp, and two output scaling stages.
// rst (synchronous) empties every stage and sets gamma_mode to 0.
// When an output beat waits, the whole pipeline holds; in_ready is high
// whenever out_ready is high or the last stage is empty.
module ycbcr_luma_gamma_adjust #(
  parameter int GAMMA_LUT_INDEX_BITS = ylga_pkg::GAMMA_LUT_INDEX_BITS_DEF,
  parameter int FRACTION_BITS        = ylga_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ylga_pkg::CH_W-1:0] red_in,
  input  logic [ylga_pkg::CH_W-1:0] green_in,
  input  logic [ylga_pkg::CH_W-1:0] blue_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ylga_pkg::CH_W-1:0] red_out,
  output logic [ylga_pkg::CH_W-1:0] green_out,
  output logic [ylga_pkg::CH_W-1:0] blue_out
);

  import ylga_pkg::*;

  localparam int F         = FRACTION_BITS;
  localparam int IB        = GAMMA_LUT_INDEX_BITS;
  localparam int SH        = F - IB;
  localparam int RND       = (2 ** SH) / 2;
  localparam int LUT_DEPTH = (2 ** IB) + 1;
  localparam int IW        = IB + 1;
  localparam int YW        = F + 1;
  localparam int DSW       = F + 1;
  localparam int RW        = F + 13;
  localparam int CLW       = F + 10;
  localparam int AW        = F + 18;
  localparam int PRW       = ACC_W + OUT_RECIP_W;
  localparam int NSTAGE    = 11;

  localparam logic signed [RW-1:0] TOP      = RW'(MILLI) << F;
  localparam logic [AW-1:0]        HALF_TOP = AW'(MILLI / 2) << F;

  logic              advance;
  logic [NSTAGE-1:0] vld;
  logic              gamma_mode;

  logic [SUM_W-1:0] s1_sum;
  logic [CH_W-1:0]  s1_r;
  logic [CH_W-1:0]  s1_b;
  logic [SUM_W-1:0] b1000;
  logic [SUM_W-1:0] r1000;

  logic [SUM_W-1:0] s2_sum;
  logic [SUM_W-1:0] s2_zb;
  logic [SUM_W-1:0] s2_zr;
  logic             s2_nb;
  logic             s2_nr;
  logic [2:0]       nb_d;
  logic [2:0]       nr_d;

  logic [YW-1:0] y_q;
  logic [F-1:0]  db_q;
  logic [F-1:0]  dr_q;
  logic [YW:0]   idx_sum;
  logic [YW:0]   idx_shift;

  logic [IW-1:0]         s6_idx;
  logic signed [DSW-1:0] s6_db;
  logic signed [DSW-1:0] s6_dr;

  logic [YW-1:0] lut0 [LUT_DEPTH];
  logic [YW-1:0] lut1 [LUT_DEPTH];

  logic [YW-1:0]         s7_ye;
  logic signed [DSW-1:0] s7_db;
  logic signed [DSW-1:0] s7_dr;

  logic signed [RW-1:0] s8_yk;
  logic signed [RW-1:0] s8_r_cr;
  logic signed [RW-1:0] s8_g_cr;
  logic signed [RW-1:0] s8_g_cb;
  logic signed [RW-1:0] s8_b_cb;

  logic signed [RW-1:0] t_ch [3];
  logic [CLW-1:0]       s9_c [3];
  logic [AW-1:0]        u_full [3];
  logic [ACC_W-1:0]     s10_u [3];
  logic [PRW-1:0]       q_full [3];
  logic [CH_W-1:0]      s11_out [3];

  // Every stage moves together unless a finished pixel is waiting.
  assign advance   = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[NSTAGE-1];
  assign red_out   = s11_out[0];
  assign green_out = s11_out[1];
  assign blue_out  = s11_out[2];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // Gamma mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_mode <= 1'b0;
    end else if (cfg_we) begin
      gamma_mode <= cfg_wdata;
    end
  end

  // Stage 1: integer luma sum in thousandths.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sum <= SUM_W'(red_in) * SUM_W'(LUMA_R) + SUM_W'(green_in) * SUM_W'(LUMA_G)
              + SUM_W'(blue_in) * SUM_W'(LUMA_B);
      s1_r   <= red_in;
      s1_b   <= blue_in;
    end
  end

  // Stage 2: magnitude and sign of the blue and red differences.
  always_comb begin
    b1000 = SUM_W'(s1_b) * SUM_W'(MILLI);
    r1000 = SUM_W'(s1_r) * SUM_W'(MILLI);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sum <= s1_sum;
      if (b1000 >= s1_sum) begin
        s2_zb <= b1000 - s1_sum;
        s2_nb <= 1'b0;
      end else begin
        s2_zb <= s1_sum - b1000;
        s2_nb <= 1'b1;
      end
      if (r1000 >= s1_sum) begin
        s2_zr <= r1000 - s1_sum;
        s2_nr <= 1'b0;
      end else begin
        s2_zr <= s1_sum - r1000;
        s2_nr <= 1'b1;
      end
    end
  end

  // Stages 3 to 5: luma and chroma scaled to F fraction bits.
  ylga_cdiv #(
    .ZW(SUM_W), .COEF(1), .D(Y_DIV), .F(F), .QW(YW)
  ) u_div_y (
    .clk(clk), .en(advance), .z(s2_sum), .q(y_q)
  );

  ylga_cdiv #(
    .ZW(SUM_W), .COEF(CB_COEF), .D(CHROMA_DIV), .F(F), .QW(F)
  ) u_div_cb (
    .clk(clk), .en(advance), .z(s2_zb), .q(db_q)
  );

  ylga_cdiv #(
    .ZW(SUM_W), .COEF(CR_COEF), .D(CHROMA_DIV), .F(F), .QW(F)
  ) u_div_cr (
    .clk(clk), .en(advance), .z(s2_zr), .q(dr_q)
  );

  // The signs wait alongside the dividers.
  always_ff @(posedge clk) begin
    if (advance) begin
      nb_d <= {nb_d[1:0], s2_nb};
      nr_d <= {nr_d[1:0], s2_nr};
    end
  end

  // Stage 6: rounded ROM index and signed chroma.
  always_comb begin
    idx_sum   = (YW+1)'(y_q) + (YW+1)'(RND);
    idx_shift = idx_sum >> SH;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_idx <= idx_shift[IW-1:0];
      s6_db  <= nb_d[2] ? -$signed({1'b0, db_q}) : $signed({1'b0, db_q});
      s6_dr  <= nr_d[2] ? -$signed({1'b0, dr_q}) : $signed({1'b0, dr_q});
    end
  end

  // Gamma ROM contents for both exponents, fixed at elaboration.
  for (genvar gi = 0; gi < LUT_DEPTH; gi++) begin : g_lut
    localparam logic [63:0] E0 = gamma_entry(gi, 0, IB, F);
    localparam logic [63:0] E1 = gamma_entry(gi, 1, IB, F);
    assign lut0[gi] = E0[YW-1:0];
    assign lut1[gi] = E1[YW-1:0];
  end

  // Stage 7: registered ROM read.
  always_ff @(posedge clk) begin
    if (advance) begin
      s7_ye <= gamma_mode ? lut1[s6_idx] : lut0[s6_idx];
      s7_db <= s6_db;
      s7_dr <= s6_dr;
    end
  end

  // Stage 8: reconstruction products in thousandths.
  always_ff @(posedge clk) begin
    if (advance) begin
      s8_yk   <= RW'(s7_ye) * RW'(MILLI);
      s8_r_cr <= RW'(s7_dr) * RW'(R_CR);
      s8_g_cr <= RW'(s7_dr) * RW'(G_CR);
      s8_g_cb <= RW'(s7_db) * RW'(G_CB);
      s8_b_cb <= RW'(s7_db) * RW'(B_CB);
    end
  end

  // Stage 9: channel sums clamped to the range zero to one.
  function automatic logic [CLW-1:0] clamp_top(input logic signed [RW-1:0] t);
    logic signed [RW-1:0] c;
    c = t;
    if (t < 0) begin
      c = '0;
    end else if (t > TOP) begin
      c = TOP;
    end
    return c[CLW-1:0];
  endfunction

  always_comb begin
    t_ch[0] = s8_yk + s8_r_cr;
    t_ch[1] = s8_yk - s8_g_cr - s8_g_cb;
    t_ch[2] = s8_yk + s8_b_cb;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s9_c[i] <= clamp_top(t_ch[i]);
      end
    end
  end

  // Stage 10: scale by 255, add half of the full scale, drop the fraction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_full[i] = (AW'(s9_c[i]) * AW'(CH_MAX) + HALF_TOP) >> F;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s10_u[i] <= u_full[i][ACC_W-1:0];
      end
    end
  end

  // Stage 11: divide by 1000 through the reciprocal into the output register.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_full[i] = (PRW'(s10_u[i]) * PRW'(OUT_RECIP)) >> OUT_RECIP_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s11_out[i] <= q_full[i][CH_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ylga_checker.sv @@
`default_nettype none

// Port-level checks on the pixel pipeline.
module ylga_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // A waiting output beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A waiting output beat keeps its pixel.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(red_out) && $stable(green_out) && $stable(blue_out))
    else $error("output pixel changed while stalled");

  // The pipeline moves whenever the sink takes a beat.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although output is taken");

  // An empty last stage never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no output waiting");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ycbcr_luma_gamma_adjust ylga_checker u_ylga_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .red_out(red_out),
  .green_out(green_out),
  .blue_out(blue_out)
);

`default_nettype wire

@@ bench/ycbcr_luma_gamma_adjust_tb.sv @@
`timescale 1ns / 100ps

module ycbcr_luma_gamma_adjust_tb;
  import ylga_pkg::*;

  localparam int LUT_BITS   = GAMMA_LUT_INDEX_BITS_DEF;
  localparam int FRAC_BITS  = FRACTION_BITS_DEF;
  localparam int LUT_TOP    = 1 << LUT_BITS;
  localparam int PIPE_DEPTH = 11;
  localparam int MAX_SHOWN  = 10;

  // Values of the gamma_mode register.
  localparam bit MODE_SOFT = 1'b0;  // exponent 0.85
  localparam bit MODE_HARD = 1'b1;  // exponent 1.50

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t src;
    pixel_t want;
  } adjust_case_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   cfg_we    = 1'b0;
  logic   cfg_wdata = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  pixel_t in_pix    = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;

  // Bench state.
  pixel_t          pixels_to_send [$];
  adjust_case_t    pending_adjusted [$];
  logic            in_took        = 1'b0;
  int              in_idle_left   = 0;
  int              out_stall_left = 0;
  int              idle_odds      = 0;
  int              fail_count     = 0;
  bit              gamma_sel      = MODE_SOFT;
  longint unsigned root_steps [1:30];
  longint unsigned gamma_rom [0:1][0:LUT_TOP];

  ycbcr_luma_gamma_adjust u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red_in    (in_pix.red),
    .green_in  (in_pix.green),
    .blue_in   (in_pix.blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Floor of the square root, one result bit at a time (inputs stay below 2^62).
  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    int b;
    root = 0;
    for (b = 30; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Signed chroma difference in F fraction bits, magnitude rounded half up.
  function automatic longint chroma_diff(longint coef, longint chan_milli, longint sum);
    longint gap;
    longint mag;
    gap = (chan_milli >= sum) ? chan_milli - sum : sum - chan_milli;
    mag = (((coef * gap) << FRAC_BITS) + CHROMA_DIV / 2) / CHROMA_DIV;
    return (chan_milli >= sum) ? mag : -mag;
  endfunction

  // Clamp a value in thousandths of F-bit fixed point to 0..1 and scale to a code.
  function automatic logic [CH_W-1:0] to_code(longint t);
    longint top;
    top = longint'(MILLI) << FRAC_BITS;
    if (t < 0) begin
      t = 0;
    end
    if (t > top) begin
      t = top;
    end
    return CH_W'((t * CH_MAX + top / 2) / top);
  endfunction

  // Expected output pixel for one input pixel under the given gamma mode.
  function automatic pixel_t adjust_pixel(pixel_t px, bit mode);
    longint sum;
    longint luma;
    longint lut_idx;
    longint y_milli;
    longint cb;
    longint cr;
    pixel_t res;
    sum     = longint'(LUMA_R) * px.red + longint'(LUMA_G) * px.green
            + longint'(LUMA_B) * px.blue;
    luma    = ((sum << FRAC_BITS) + Y_DIV / 2) / Y_DIV;
    lut_idx = (luma + (longint'(1) << (FRAC_BITS - LUT_BITS - 1)))
              >> (FRAC_BITS - LUT_BITS);
    if (lut_idx > LUT_TOP) begin
      lut_idx = LUT_TOP;
    end
    y_milli   = longint'(gamma_rom[mode][lut_idx]) * MILLI;
    cb        = chroma_diff(CB_COEF, longint'(MILLI) * px.blue, sum);
    cr        = chroma_diff(CR_COEF, longint'(MILLI) * px.red, sum);
    res.red   = to_code(y_milli + R_CR * cr);
    res.green = to_code(y_milli - G_CR * cr - G_CB * cb);
    res.blue  = to_code(y_milli + B_CB * cb);
    return res;
  endfunction

  // Pixel sender: holds a beat until it is taken, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      in_idle_left <= 0;
    end else if (!in_valid || in_took) begin
      if (in_idle_left != 0) begin
        in_valid     <= 1'b0;
        in_idle_left <= in_idle_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        in_valid     <= 1'b0;
        in_idle_left <= $urandom_range(0, 8);
      end else if (pixels_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_pix   <= pixels_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready      <= 1'b0;
      out_stall_left <= 0;
    end else if (out_stall_left != 0) begin
      out_ready      <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready      <= 1'b0;
      out_stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk) begin : check_outputs
    adjust_case_t head;
    in_took <= !rst && in_valid && in_ready;
    if (rst) begin
      gamma_sel <= MODE_SOFT;
    end else begin
      if (cfg_we) begin
        gamma_sel <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        head.src  = in_pix;
        head.want = adjust_pixel(in_pix, gamma_sel);
        pending_adjusted.push_back(head);
      end
      if (out_valid && out_ready) begin
        if (pending_adjusted.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("unexpected output beat %0d/%0d/%0d", red_out, green_out, blue_out);
          end
        end else begin
          head = pending_adjusted.pop_front();
          if (head.want.red !== red_out || head.want.green !== green_out ||
              head.want.blue !== blue_out) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
              $display("pixel %0d/%0d/%0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       head.src.red, head.src.green, head.src.blue,
                       head.want.red, head.want.green, head.want.blue,
                       red_out, green_out, blue_out);
            end
          end
        end
      end
    end
  end

  // Wait until every queued pixel has been sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pixels_to_send.size() != 0 || in_valid || pending_adjusted.size() != 0);
  endtask

  // Change gamma_mode only while the pipeline is empty.
  task automatic write_gamma_mode(bit mode);
    wait_drained();
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Corner pixels: black, white, primaries, secondaries, mid gray and near-extremes.
  task automatic queue_directed();
    @(posedge clk);
    pixels_to_send.push_back('{8'd0,   8'd0,   8'd0});
    pixels_to_send.push_back('{8'd255, 8'd255, 8'd255});
    pixels_to_send.push_back('{8'd255, 8'd0,   8'd0});
    pixels_to_send.push_back('{8'd0,   8'd255, 8'd0});
    pixels_to_send.push_back('{8'd0,   8'd0,   8'd255});
    pixels_to_send.push_back('{8'd255, 8'd255, 8'd0});
    pixels_to_send.push_back('{8'd0,   8'd255, 8'd255});
    pixels_to_send.push_back('{8'd255, 8'd0,   8'd255});
    pixels_to_send.push_back('{8'd128, 8'd128, 8'd128});
    pixels_to_send.push_back('{8'd1,   8'd1,   8'd1});
    pixels_to_send.push_back('{8'd254, 8'd0,   8'd1});
    pixels_to_send.push_back('{8'd0,   8'd1,   8'd254});
  endtask

  // Random pixels: some grays, the rest with channels that favor the rails.
  task automatic queue_random(int count, int odds);
    pixel_t px;
    int i;
    logic [CH_W-1:0] ch [3];
    int c;
    @(posedge clk);
    idle_odds = odds;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        px.red   = CH_W'($urandom_range(0, 255));
        px.green = px.red;
        px.blue  = px.red;
      end else begin
        for (c = 0; c < 3; c++) begin
          case ($urandom_range(0, 7))
            0: begin
              ch[c] = 8'd0;
            end
            1: begin
              ch[c] = 8'd255;
            end
            default: begin
              ch[c] = CH_W'($urandom_range(0, 255));
            end
          endcase
        end
        px = '{ch[0], ch[1], ch[2]};
      end
      pixels_to_send.push_back(px);
    end
  endtask

  initial begin : stimulus
    longint unsigned mant;
    longint unsigned frac;
    longint unsigned mag;
    longint unsigned scaled;
    longint unsigned frac_part;
    longint unsigned acc;
    longint unsigned shift;
    int unsigned msb;
    int unsigned k;
    int unsigned idx;
    int mode;

    // Gamma table: Q30 log2 by repeated squaring, scale, Q30 exp2 from roots of two.
    root_steps[1] = sqrt_floor(64'd1 << 59);
    for (k = 2; k <= 30; k++) begin
      root_steps[k] = sqrt_floor(root_steps[k-1] << 30);
    end
    for (mode = 0; mode < 2; mode++) begin
      for (idx = 0; idx <= LUT_TOP; idx++) begin
        if (idx == 0) begin
          gamma_rom[mode][idx] = 0;
        end else begin
          msb = 0;
          while ((idx >> (msb + 1)) != 0) begin
            msb++;
          end
          mant = 64'(idx) << (30 - msb);
          frac = 0;
          for (k = 1; k <= 30; k++) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30)) begin
              mant = mant >> 1;
              frac = frac | (64'd1 << (30 - k));
            end
          end
          mag       = (64'(LUT_BITS - msb) << 30) - frac;
          scaled    = (mode != 0) ? mag * 64'd3 / 64'd2 : mag * 64'd17 / 64'd20;
          frac_part = scaled & ((64'd1 << 30) - 64'd1);
          acc       = 64'd1 << 30;
          for (k = 1; k <= 30; k++) begin
            if (frac_part[30 - k]) begin
              acc = (acc * root_steps[k]) >> 30;
            end
          end
          shift = 64'(30 - FRAC_BITS) + (scaled >> 30);
          gamma_rom[mode][idx] = (shift >= 40) ? 64'd0
                               : (acc + (64'd1 << (shift - 1))) >> shift;
        end
      end
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed corners under the reset mode, then under the steep curve.
    idle_odds = 6;
    queue_directed();
    write_gamma_mode(MODE_HARD);
    queue_directed();

    // Random phases; each mode change waits for the pipeline to empty.
    write_gamma_mode(MODE_SOFT);
    queue_random(550, 6);
    write_gamma_mode(MODE_HARD);
    queue_random(550, 4);
    write_gamma_mode(MODE_SOFT);
    queue_random(250, 10);
    write_gamma_mode(MODE_HARD);
    queue_random(400, 0);

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (fail_count == 0 && pending_adjusted.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Safety net against a stuck handshake.
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ ycbcr_luma_gamma_adjust.f @@
design/ylga_pkg.sv
design/ylga_cdiv.sv
design/ycbcr_luma_gamma_adjust.sv
design/ylga_checker.sv
bench/ycbcr_luma_gamma_adjust_tb.sv
